@@ hw/rtl/tak_pkg.sv @@
// ----------------------------------------------------------------------------
// tak_pkg
// types, register codes and fixed-point helpers of the tilt kalman filter
// ----------------------------------------------------------------------------
package tak_pkg;

  localparam int unsigned WordWidthDef = 32;
  localparam int unsigned RegWidth     = 31;
  localparam int unsigned FieldWidth   = 32;

  localparam logic [RegWidth-1:0] PeriodRst  = 31'd10737418;
  localparam logic [RegWidth-1:0] AngNoiseRst = 31'd1073742;
  localparam logic [RegWidth-1:0] BiasNoiseRst = 31'd5368709;
  localparam logic [RegWidth-1:0] MeasNoiseRst = 31'd536870912;
  localparam logic [31:0]         Q30One     = 32'd1073741824;

  typedef enum logic [1:0] {
    CFG_PERIOD     = 2'd0,
    CFG_ANG_NOISE  = 2'd1,
    CFG_BIAS_NOISE = 2'd2,
    CFG_MEAS_NOISE = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRE, ST_MUL, ST_ACC, ST_DSET, ST_DIV, ST_DEND, ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_ANG_P   = 4'd0,
    OP_P00     = 4'd1,
    OP_P01_P10 = 4'd2,
    OP_P11     = 4'd3,
    OP_C00     = 4'd4,
    OP_C01     = 4'd5,
    OP_C10     = 4'd6,
    OP_C11     = 4'd7,
    OP_ANG     = 4'd8,
    OP_BIAS    = 4'd9
  } op_e;

  // q2.30 product rounded half up, then floored
  function automatic logic signed [34:0] qround(input logic signed [63:0] p);
    logic signed [64:0] t;
    t = {p[63], p} + 65'sd536870912;
    return t[64:30];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > 40'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -40'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [39:0] ext32(input logic [31:0] v);
    return {{8{v[31]}}, v};
  endfunction

  function automatic logic signed [39:0] ext35(input logic signed [34:0] v);
    return {{5{v[34]}}, v};
  endfunction

endpackage

@@ hw/rtl/tak_if.sv @@
// ----------------------------------------------------------------------------
// tak_in_if / tak_out_if
// valid/ready channels carrying sensor samples and filter results
// ----------------------------------------------------------------------------
interface tak_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] angle_meas;
  logic [31:0] rate_meas;
  modport source (output valid, angle_meas, rate_meas, input ready);
  modport sink   (input valid, angle_meas, rate_meas, output ready);
endinterface

interface tak_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] angle_out;
  logic [31:0] rate_out;
  modport source (output valid, angle_out, rate_out, input ready);
  modport sink   (input valid, angle_out, rate_out, output ready);
endinterface

@@ hw/rtl/tilt_angle_kalman_filter_top.sv @@
// ----------------------------------------------------------------------------
// tilt_angle_kalman_filter_top
// two-state angle / gyro-bias kalman filter on one shared multiplier
// ----------------------------------------------------------------------------
// One sample in, one result out. Between its input beat and its result beat a
// sample runs ten products through the one 32x32 multiplier, each a multiply
// state and an accumulate state, and two gain divisions on a bit-serial
// restoring divider of 62 steps, each set up in ST_DSET and closed in ST_DEND. The
// input is ready only while the filter is idle, and the result is held until it is taken.
module tilt_angle_kalman_filter_top #(
  parameter int unsigned WORD_WIDTH = tak_pkg::WordWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  tak_in_if.sink      in_s,
  tak_out_if.source   out_s
);

  localparam int unsigned AngBits = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
  localparam logic signed [39:0] AngHi = (40'sd1 <<< (AngBits - 1)) - 40'sd1;
  localparam logic signed [39:0] AngLo = -AngHi - 40'sd1;

  function automatic logic [31:0] sat_ang(input logic signed [39:0] v);
    logic signed [39:0] r;
    if (v > AngHi) r = AngHi;
    else if (v < AngLo) r = AngLo;
    else r = v;
    return r[31:0];
  endfunction

  tak_pkg::state_e state_q, state_d;
  logic [3:0]  op_q;
  logic [5:0]  cnt_q;
  logic        div_sel_q, neg_q;

  logic [30:0] period_q, ang_noise_q, bias_noise_q, meas_noise_q;
  logic [31:0] ang_q, bias_q, c00_q, c01_q, c10_q, c11_q;
  logic [31:0] am_q, rm_q, diff_q, pdot_q, angp_q, err_q;
  logic [31:0] p00_q, p01_q, p10_q, p11_q, k0_q, k1_q, rate_q;
  logic [31:0] e_q, rem_q;
  logic [61:0] quo_q;
  logic signed [63:0] prod_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [34:0] qm;
  logic [32:0] trial;
  logic [31:0] div_num, div_mag, kres;
  logic signed [33:0] e_sum;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= tak_pkg::PeriodRst;
      ang_noise_q  <= tak_pkg::AngNoiseRst;
      bias_noise_q <= tak_pkg::BiasNoiseRst;
      meas_noise_q <= tak_pkg::MeasNoiseRst;
    end else if (cfg_we_i) begin
      unique case (tak_pkg::cfg_idx_e'(cfg_idx_i))
        tak_pkg::CFG_PERIOD:     period_q     <= cfg_data_i;
        tak_pkg::CFG_ANG_NOISE:  ang_noise_q  <= cfg_data_i;
        tak_pkg::CFG_BIAS_NOISE: bias_noise_q <= cfg_data_i;
        tak_pkg::CFG_MEAS_NOISE: meas_noise_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (tak_pkg::op_e'(op_q))
      tak_pkg::OP_ANG_P:   begin mul_a = diff_q; mul_b = {1'b0, period_q}; end
      tak_pkg::OP_P00:     begin mul_a = pdot_q; mul_b = {1'b0, period_q}; end
      tak_pkg::OP_P01_P10: begin mul_a = c11_q; mul_b = {1'b0, period_q}; end
      tak_pkg::OP_P11:     begin mul_a = {1'b0, bias_noise_q}; mul_b = {1'b0, period_q}; end
      tak_pkg::OP_C00:     begin mul_a = k0_q; mul_b = p00_q; end
      tak_pkg::OP_C01:     begin mul_a = k0_q; mul_b = p01_q; end
      tak_pkg::OP_C10:     begin mul_a = k1_q; mul_b = p00_q; end
      tak_pkg::OP_C11:     begin mul_a = k1_q; mul_b = p01_q; end
      tak_pkg::OP_ANG:     begin mul_a = k0_q; mul_b = err_q; end
      tak_pkg::OP_BIAS:    begin mul_a = k1_q; mul_b = err_q; end
      default: ;
    endcase
  end

  assign qm = tak_pkg::qround(prod_q);

  // divider helpers
  assign div_num = div_sel_q ? p10_q : p00_q;
  assign div_mag = div_num[31] ? (32'd0 - div_num) : div_num;
  assign trial   = {rem_q, quo_q[61]};
  assign e_sum   = {3'b000, meas_noise_q} + {{2{p00_q[31]}}, p00_q};

  always_comb begin
    if (!neg_q) begin
      kres = (quo_q > 62'd2147483647) ? 32'h7fff_ffff : quo_q[31:0];
    end else begin
      kres = (quo_q > 62'd2147483648) ? 32'h8000_0000 : (32'd0 - quo_q[31:0]);
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= tak_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    in_s.ready  = 1'b0;
    out_s.valid = 1'b0;
    unique case (state_q)
      tak_pkg::ST_IDLE: begin
        in_s.ready = 1'b1;
        if (in_s.valid) state_d = tak_pkg::ST_PRE;
      end
      tak_pkg::ST_PRE: state_d = tak_pkg::ST_MUL;
      tak_pkg::ST_MUL: state_d = tak_pkg::ST_ACC;
      tak_pkg::ST_ACC: begin
        if (op_q == tak_pkg::OP_P11) state_d = tak_pkg::ST_DSET;
        else if (op_q == tak_pkg::OP_BIAS) state_d = tak_pkg::ST_FIN;
        else state_d = tak_pkg::ST_MUL;
      end
      tak_pkg::ST_DSET: state_d = tak_pkg::ST_DIV;
      tak_pkg::ST_DIV: if (cnt_q == 6'd61) state_d = tak_pkg::ST_DEND;
      tak_pkg::ST_DEND: state_d = div_sel_q ? tak_pkg::ST_MUL : tak_pkg::ST_DSET;
      tak_pkg::ST_FIN: begin
        out_s.valid = 1'b1;
        if (out_s.ready) state_d = tak_pkg::ST_IDLE;
      end
      default: state_d = tak_pkg::ST_IDLE;
    endcase
  end

  assign out_s.angle_out = ang_q;
  assign out_s.rate_out  = rate_q;

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q      <= '0;
      cnt_q     <= '0;
      div_sel_q <= 1'b0;
    end else begin
      unique case (state_q)
        tak_pkg::ST_PRE: begin
          op_q      <= tak_pkg::OP_ANG_P;
          div_sel_q <= 1'b0;
        end
        tak_pkg::ST_ACC: if (op_q != tak_pkg::OP_P11) op_q <= op_q + 4'd1;
        tak_pkg::ST_DSET: cnt_q <= '0;
        tak_pkg::ST_DIV: cnt_q <= cnt_q + 6'd1;
        tak_pkg::ST_DEND: begin
          div_sel_q <= 1'b1;
          if (div_sel_q) op_q <= tak_pkg::OP_C00;
        end
        default: ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q  <= '0;
      bias_q <= '0;
      c00_q  <= tak_pkg::Q30One;
      c01_q  <= '0;
      c10_q  <= '0;
      c11_q  <= tak_pkg::Q30One;
    end else if (state_q == tak_pkg::ST_ACC) begin
      case (tak_pkg::op_e'(op_q))
        tak_pkg::OP_C00:  c00_q <= tak_pkg::sat32(tak_pkg::ext32(p00_q) - tak_pkg::ext35(qm));
        tak_pkg::OP_C01:  c01_q <= tak_pkg::sat32(tak_pkg::ext32(p01_q) - tak_pkg::ext35(qm));
        tak_pkg::OP_C10:  c10_q <= tak_pkg::sat32(tak_pkg::ext32(p10_q) - tak_pkg::ext35(qm));
        tak_pkg::OP_C11:  c11_q <= tak_pkg::sat32(tak_pkg::ext32(p11_q) - tak_pkg::ext35(qm));
        tak_pkg::OP_ANG:  ang_q <= sat_ang(tak_pkg::ext32(angp_q) + tak_pkg::ext35(qm));
        tak_pkg::OP_BIAS: bias_q <= sat_ang(tak_pkg::ext32(bias_q) + tak_pkg::ext35(qm));
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      tak_pkg::ST_IDLE: begin
        am_q <= in_s.angle_meas;
        rm_q <= in_s.rate_meas;
      end
      tak_pkg::ST_PRE: begin
        diff_q <= sat_ang(tak_pkg::ext32(rm_q) - tak_pkg::ext32(bias_q));
        pdot_q <= tak_pkg::sat32({9'd0, ang_noise_q} - tak_pkg::ext32(c01_q)
                                 - tak_pkg::ext32(c10_q));
      end
      tak_pkg::ST_MUL: prod_q <= mul_a * mul_b;
      tak_pkg::ST_ACC: begin
        case (tak_pkg::op_e'(op_q))
          tak_pkg::OP_ANG_P: angp_q <= sat_ang(tak_pkg::ext32(ang_q) + tak_pkg::ext35(qm));
          tak_pkg::OP_P00: begin
            p00_q <= tak_pkg::sat32(tak_pkg::ext32(c00_q) + tak_pkg::ext35(qm));
            err_q <= sat_ang(tak_pkg::ext32(am_q) - tak_pkg::ext32(angp_q));
          end
          tak_pkg::OP_P01_P10: begin
            p01_q <= tak_pkg::sat32(tak_pkg::ext32(c01_q) - tak_pkg::ext35(qm));
            p10_q <= tak_pkg::sat32(tak_pkg::ext32(c10_q) - tak_pkg::ext35(qm));
          end
          tak_pkg::OP_P11: p11_q <= tak_pkg::sat32(tak_pkg::ext32(c11_q) + tak_pkg::ext35(qm));
          default: ;
        endcase
      end
      tak_pkg::ST_DSET: begin
        e_q   <= (e_sum < 34'sd1) ? 32'd1 : e_sum[31:0];
        rem_q <= '0;
        quo_q <= {div_mag, 30'd0};
        neg_q <= div_num[31];
      end
      tak_pkg::ST_DIV: begin
        // restoring step, one quotient bit a cycle
        if (trial >= {1'b0, e_q}) begin
          rem_q <= 32'(trial - {1'b0, e_q});
          quo_q <= {quo_q[60:0], 1'b1};
        end else begin
          rem_q <= trial[31:0];
          quo_q <= {quo_q[60:0], 1'b0};
        end
      end
      tak_pkg::ST_DEND: begin
        if (div_sel_q) k1_q <= kres;
        else           k0_q <= kres;
      end
      tak_pkg::ST_FIN: begin
        if (!out_s.valid || !out_s.ready) rate_q <= rate_q;
      end
      default: ;
    endcase
    if (state_q == tak_pkg::ST_ACC && op_q == tak_pkg::OP_BIAS) begin
      rate_q <= sat_ang(tak_pkg::ext32(rm_q) - tak_pkg::ext32(sat_ang(
                tak_pkg::ext32(bias_q) + tak_pkg::ext35(qm))));
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_s.ready |-> !out_s.valid) else $error("input ready while result pending");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tak_pkg::ST_DIV) |-> (e_q != '0)) else $error("zero divisor");

  a_out_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_s.valid && out_s.ready) |=> in_s.ready) else $error("no return to idle");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tak_pkg::ST_DEND) |-> ($past(cnt_q) == 6'd61))
    else $error("divider step count wrong");

endmodule

@@ tb/tilt_angle_kalman_filter_top_test.sv @@
// ----------------------------------------------------------------------------
// tilt_angle_kalman_filter_top_test
// checks the filter against a cycle-free predictor of its state and outputs,
// over directed edge samples, random samples and several register settings
// ----------------------------------------------------------------------------
module tilt_angle_kalman_filter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Latency   = 200;
  localparam int unsigned StallLim  = 20000;

  typedef struct packed {
    logic [31:0] angle;
    logic [31:0] rate;
  } sample_t;

  typedef struct packed {
    logic [31:0] angle;
    logic [31:0] rate;
  } estimate_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [30:0] cfg_data_i;

  tak_in_if  in_if ();
  tak_out_if out_if ();

  tilt_angle_kalman_filter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_s       (in_if.sink),
    .out_s      (out_if.source)
  );

  // predictor state
  longint dt_q, q_ang, q_bias, r_meas;
  longint ang_est, bias_est, p00_q, p01_q, p10_q, p11_q;

  sample_t   sample_q[$];
  estimate_t estimate_q[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned burst_left, gap_left, hold_left;
  bit sender_pause;

  function automatic longint floor_div30(input longint v);
    return v >>> 30;
  endfunction

  function automatic longint qprod(input longint a, input longint b);
    return floor_div30(a * b + 64'sd536870912);
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void filter_reset();
    dt_q = tak_pkg::PeriodRst;
    q_ang = tak_pkg::AngNoiseRst;
    q_bias = tak_pkg::BiasNoiseRst;
    r_meas = tak_pkg::MeasNoiseRst;
    ang_est = 0;
    bias_est = 0;
    p00_q = 64'sd1073741824;
    p01_q = 0;
    p10_q = 0;
    p11_q = 64'sd1073741824;
  endfunction

  function automatic estimate_t filter_step(input sample_t s);
    longint am, rm, diff, ang_p, err, pdot, p00, p01, p10, p11, e, k0, k1, rate;
    estimate_t r;
    am = longint'($signed(s.angle));
    rm = longint'($signed(s.rate));
    diff = clip32(rm - bias_est);
    ang_p = clip32(ang_est + qprod(diff, dt_q));
    err = clip32(am - ang_p);
    pdot = clip32(q_ang - p01_q - p10_q);
    p00 = clip32(p00_q + qprod(pdot, dt_q));
    p01 = clip32(p01_q - qprod(p11_q, dt_q));
    p10 = clip32(p10_q - qprod(p11_q, dt_q));
    p11 = clip32(p11_q + qprod(q_bias, dt_q));
    e = r_meas + p00;
    if (e < 1) e = 1;
    k0 = clip32((p00 * 64'sd1073741824) / e);
    k1 = clip32((p10 * 64'sd1073741824) / e);
    p00_q = clip32(p00 - qprod(k0, p00));
    p01_q = clip32(p01 - qprod(k0, p01));
    p10_q = clip32(p10 - qprod(k1, p00));
    p11_q = clip32(p11 - qprod(k1, p01));
    ang_est = clip32(ang_p + qprod(k0, err));
    bias_est = clip32(bias_est + qprod(k1, err));
    rate = clip32(rm - bias_est);
    r.angle = ang_est[31:0];
    r.rate = rate[31:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    mismatches++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // driver: bursts and gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.angle_meas <= '0;
      in_if.rate_meas <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      automatic bit fire = in_if.valid && in_if.ready;
      automatic bit busy = in_if.valid && !in_if.ready;
      if (fire) begin
        automatic sample_t s = sample_q.pop_front();
        estimate_q.push_back(filter_step(s));
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (sample_q.size() > 0 && !sender_pause) begin
          in_if.valid <= 1'b1;
          in_if.angle_meas <= sample_q[0].angle;
          in_if.rate_meas <= sample_q[0].rate;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 8);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 300);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor with its own stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (estimate_q.size() == 0) begin
          report("unexpected result beat", out_if.angle_out, '0);
        end else begin
          automatic estimate_t e = estimate_q.pop_front();
          if (out_if.angle_out !== e.angle) report("angle_out", out_if.angle_out, e.angle);
          if (out_if.rate_out !== e.rate) report("rate_out", out_if.rate_out, e.rate);
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (hold_left > 0) out_if.ready <= 1'b0;
      else out_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= StallLim) begin
      $display("tilt_angle_kalman_filter_top_test NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input tak_pkg::cfg_idx_e idx, input logic [30:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tak_pkg::CFG_PERIOD:     dt_q = val;
      tak_pkg::CFG_ANG_NOISE:  q_ang = val;
      tak_pkg::CFG_BIAS_NOISE: q_bias = val;
      tak_pkg::CFG_MEAS_NOISE: r_meas = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (sample_q.size() > 0 || in_if.valid || estimate_q.size() > 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 200 << 16)) - (100 << 16);
    endcase
  endfunction

  task automatic queue_random(input int n);
    sample_t s;
    for (int i = 0; i < n; i++) begin
      s.angle = rand_field();
      s.rate = rand_field();
      sample_q.push_back(s);
    end
  endtask

  initial begin
    sample_t s;
    mismatches = 0;
    hold_left = 0;
    sender_pause = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = tak_pkg::CFG_PERIOD;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    filter_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes
    s = '{32'h0000_0000, 32'h0000_0000}; sample_q.push_back(s);
    s = '{32'h7fff_ffff, 32'h7fff_ffff}; sample_q.push_back(s);
    s = '{32'h8000_0000, 32'h8000_0000}; sample_q.push_back(s);
    s = '{32'h7fff_ffff, 32'h8000_0000}; sample_q.push_back(s);
    s = '{32'hffff_ffff, 32'h0000_0001}; sample_q.push_back(s);
    s = '{32'h0005_0000, 32'hfffb_0000}; sample_q.push_back(s);
    drain();

    // zero period predicts nothing
    write_reg(tak_pkg::CFG_PERIOD, '0);
    queue_random(4);
    drain();

    // smallest nonzero measurement noise, largest process noise
    write_reg(tak_pkg::CFG_PERIOD, 31'h7fff_ffff);
    write_reg(tak_pkg::CFG_ANG_NOISE, 31'h7fff_ffff);
    write_reg(tak_pkg::CFG_BIAS_NOISE, 31'h7fff_ffff);
    write_reg(tak_pkg::CFG_MEAS_NOISE, 31'd1);
    queue_random(8);
    drain();

    // zero process noises, largest measurement noise
    write_reg(tak_pkg::CFG_ANG_NOISE, '0);
    write_reg(tak_pkg::CFG_BIAS_NOISE, '0);
    write_reg(tak_pkg::CFG_MEAS_NOISE, 31'h7fff_ffff);
    write_reg(tak_pkg::CFG_PERIOD, 31'd1);
    queue_random(6);
    drain();

    // back to nominal values, long receiver hold while the sender keeps offering
    write_reg(tak_pkg::CFG_PERIOD, tak_pkg::PeriodRst);
    write_reg(tak_pkg::CFG_ANG_NOISE, tak_pkg::AngNoiseRst);
    write_reg(tak_pkg::CFG_BIAS_NOISE, tak_pkg::BiasNoiseRst);
    write_reg(tak_pkg::CFG_MEAS_NOISE, tak_pkg::MeasNoiseRst);
    hold_left = 2000;
    queue_random(300);
    drain();

    // random settings
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(tak_pkg::CFG_PERIOD,
                31'($urandom_range(0, 31'h7fff_ffff) >> $urandom_range(0, 30)));
      write_reg(tak_pkg::CFG_ANG_NOISE,
                31'($urandom_range(0, 31'h7fff_ffff) >> $urandom_range(0, 30)));
      write_reg(tak_pkg::CFG_BIAS_NOISE,
                31'($urandom_range(0, 31'h7fff_ffff) >> $urandom_range(0, 30)));
      write_reg(tak_pkg::CFG_MEAS_NOISE,
                31'(($urandom_range(1, 31'h7fff_ffff) >> $urandom_range(0, 30)) | 1));
      queue_random(175);
      drain();
    end

    if (mismatches == 0) begin
      $display("tilt_angle_kalman_filter_top_test OK");
    end else begin
      $display("tilt_angle_kalman_filter_top_test NOT OK");
    end
    $finish;
  end
endmodule

@@ tilt_angle_kalman_filter_top.f @@
hw/rtl/tak_pkg.sv
hw/rtl/tak_if.sv
hw/rtl/tilt_angle_kalman_filter_top.sv
tb/tilt_angle_kalman_filter_top_test.sv
